### hw/rtl/chss_pkg.sv
// Package for the convex hull stack scan unit: widths, defaults and shared types.
package chss_pkg;

    localparam int CHSS_STACK_DEPTH = 64;

    localparam int COORD_W = 32;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int HALF_W  = 16;
    localparam int SLICE_W = DIFF_W - HALF_W;
    localparam int PROD_W  = DIFF_W + SLICE_W;
    localparam int ACC_W   = PROD_W + HALF_W + 1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [ACC_W-1:0]   acc_t;

    typedef struct packed {
        logic done;
        logic left_turn;
    } cross_status_t;

endpackage

### hw/rtl/chss_stack_mem.sv
// Hull stack storage: one write port and one registered read port for x and y.
module chss_stack_mem
    import chss_pkg::*;
#(
    parameter int DEPTH = CHSS_STACK_DEPTH,
    parameter int AW    = $clog2(CHSS_STACK_DEPTH)
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  coord_t        wr_x,
    input  coord_t        wr_y,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output coord_t        rd_x,
    output coord_t        rd_y
);

    coord_t mem_x [DEPTH];
    coord_t mem_y [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_x[wr_addr] <= wr_x;
            mem_y[wr_addr] <= wr_y;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_x <= mem_x[rd_addr];
            rd_y <= mem_y[rd_addr];
        end
    end

endmodule

### hw/rtl/chss_cross_unit.sv
// Turn test: exact cross product sign from one shared 33x17 multiplier over four steps.
module chss_cross_unit
    import chss_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  coord_t        n_x,
    input  coord_t        n_y,
    input  coord_t        t_x,
    input  coord_t        t_y,
    input  coord_t        p_x,
    input  coord_t        p_y,
    output cross_status_t status
);

    diff_t       dtx_reg, dty_reg, dpx_reg, dpy_reg;
    prod_t       prod_reg;
    acc_t        acc_reg;
    logic        active_reg;
    logic        done_reg;
    logic [2:0]  step_reg;

    diff_t                      a_sel;
    logic signed [SLICE_W-1:0]  b_sel;
    prod_t                      prod_next;
    acc_t                       term;
    logic [1:0]                 prev_step;

    // Steps 0 and 1 form dtx*dpy (low then high slice), steps 2 and 3 form dty*dpx.
    always_comb begin
        a_sel = (step_reg[1] == 1'b0) ? dtx_reg : dty_reg;
        case (step_reg[1:0])
            2'd0:    b_sel = {1'b0, dpy_reg[HALF_W-1:0]};
            2'd1:    b_sel = dpy_reg[DIFF_W-1:HALF_W];
            2'd2:    b_sel = {1'b0, dpx_reg[HALF_W-1:0]};
            default: b_sel = dpx_reg[DIFF_W-1:HALF_W];
        endcase
        prod_next = a_sel * b_sel;
    end

    // The product register holds the multiplier output from the previous step.
    always_comb begin
        prev_step = 2'(step_reg - 3'd1);
        if (prev_step[0]) begin
            term = {prod_reg[PROD_W-1], prod_reg, {HALF_W{1'b0}}};
        end else begin
            term = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dtx_reg <= diff_t'(t_x) - diff_t'(n_x);
            dty_reg <= diff_t'(t_y) - diff_t'(n_y);
            dpx_reg <= diff_t'(p_x) - diff_t'(n_x);
            dpy_reg <= diff_t'(p_y) - diff_t'(n_y);
            acc_reg <= '0;
        end else if (active_reg) begin
            if (step_reg != 3'd4) begin
                prod_reg <= prod_next;
            end
            if (step_reg != 3'd0) begin
                if (prev_step[1]) begin
                    acc_reg <= acc_reg - term;
                end else begin
                    acc_reg <= acc_reg + term;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            step_reg   <= 3'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                active_reg <= 1'b1;
                step_reg   <= 3'd0;
            end else if (active_reg) begin
                if (step_reg == 3'd4) begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end else begin
                    step_reg <= step_reg + 3'd1;
                end
            end
        end
    end

    assign status.done      = done_reg;
    assign status.left_turn = !acc_reg[ACC_W-1] && (acc_reg != '0);

endmodule

### hw/rtl/convex_hull_stack_scan_unit.sv
// Convex hull stack scan unit: Graham scan stack stage with a sequencer and shared turn test.
// Points arrive sorted by angle around the pivot; a pivot item restarts the hull. The unit
// takes one item at a time and holds s_ready low while it works. A pivot or a point pushed
// without a test goes straight to the push state. Every turn test against the stack passes
// through the difference stage, five multiplier and accumulate steps of the shared 33x17
// multiplier and the step that acts on the result, which also issues the next stack read;
// a point that finds at least two entries runs one test per pop and one more unless its
// pops stop at the two-entry floor, with at most one pop per point on average. On an item
// marked last, the hull is sent top of stack first after an extra read state, one vertex
// at a time: the next vertex is read only once m_ready takes the current one. After reset
// the stack is empty and no clearing pass is needed.
module convex_hull_stack_scan_unit
    import chss_pkg::*;
#(
    parameter int STACK_DEPTH = CHSS_STACK_DEPTH
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_valid,
    output logic   s_ready,
    input  coord_t s_point_x,
    input  coord_t s_point_y,
    input  logic   s_is_pivot,
    input  logic   s_is_last,
    output logic   m_valid,
    input  logic   m_ready,
    output coord_t m_hull_x,
    output coord_t m_hull_y,
    output logic   m_hull_end,
    output logic   m_overflow
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_LOADN     = 3'd1;
    localparam logic [2:0] S_CROSS     = 3'd2;
    localparam logic [2:0] S_PUSH      = 3'd3;
    localparam logic [2:0] S_EMIT_RD   = 3'd4;
    localparam logic [2:0] S_EMIT_LD   = 3'd5;
    localparam logic [2:0] S_EMIT_WAIT = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic          m_valid_reg, m_valid_next;
    coord_t        px_reg, px_next, py_reg, py_next;
    logic          last_reg, last_next;
    coord_t        top_x_reg, top_x_next, top_y_reg, top_y_next;
    coord_t        nx_reg, nx_next, ny_reg, ny_next;
    coord_t        hx_reg, hx_next, hy_reg, hy_next;
    logic          hend_reg, hend_next;
    logic          hovf_reg, hovf_next;

    logic          rd_en, wr_en;
    logic [CW-1:0] rd_ptr;
    coord_t        rd_x, rd_y;
    logic          cross_start;
    cross_status_t cross_st;

    chss_stack_mem #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_x    (px_reg),
        .wr_y    (py_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_ptr[AW-1:0]),
        .rd_x    (rd_x),
        .rd_y    (rd_y)
    );

    chss_cross_unit u_cross (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cross_start),
        .n_x     (rd_x),
        .n_y     (rd_y),
        .t_x     (top_x_reg),
        .t_y     (top_y_reg),
        .p_x     (px_reg),
        .p_y     (py_reg),
        .status  (cross_st)
    );

    assign s_ready     = (state_reg == S_IDLE);
    assign cross_start = (state_reg == S_LOADN);

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        m_valid_next = m_valid_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        last_next    = last_reg;
        top_x_next   = top_x_reg;
        top_y_next   = top_y_reg;
        nx_next      = nx_reg;
        ny_next      = ny_reg;
        hx_next      = hx_reg;
        hy_next      = hy_reg;
        hend_next    = hend_reg;
        hovf_next    = hovf_reg;
        rd_en        = 1'b0;
        rd_ptr       = count_reg - CW'(1);
        wr_en        = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    px_next   = s_point_x;
                    py_next   = s_point_y;
                    last_next = s_is_last;
                    if (s_is_pivot) begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = S_PUSH;
                    end else if (count_reg >= CW'(2)) begin
                        rd_en      = 1'b1;
                        rd_ptr     = count_reg - CW'(2);
                        state_next = S_LOADN;
                    end else begin
                        state_next = S_PUSH;
                    end
                end
            end
            S_LOADN: begin
                nx_next    = rd_x;
                ny_next    = rd_y;
                state_next = S_CROSS;
            end
            S_CROSS: begin
                if (cross_st.done) begin
                    if (cross_st.left_turn) begin
                        state_next = S_PUSH;
                    end else begin
                        // Pop: the next-to-top entry becomes the top.
                        count_next = count_reg - CW'(1);
                        top_x_next = nx_reg;
                        top_y_next = ny_reg;
                        if (count_reg >= CW'(3)) begin
                            rd_en      = 1'b1;
                            rd_ptr     = count_reg - CW'(3);
                            state_next = S_LOADN;
                        end else begin
                            state_next = S_PUSH;
                        end
                    end
                end
            end
            S_PUSH: begin
                if (count_reg >= CW'(STACK_DEPTH)) begin
                    ovf_next = 1'b1;
                end else begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CW'(1);
                    top_x_next = px_reg;
                    top_y_next = py_reg;
                end
                state_next = last_reg ? S_EMIT_RD : S_IDLE;
            end
            S_EMIT_RD: begin
                rd_en      = 1'b1;
                state_next = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                hx_next      = rd_x;
                hy_next      = rd_y;
                hend_next    = (count_reg == CW'(1));
                hovf_next    = ovf_reg;
                m_valid_next = 1'b1;
                count_next   = count_reg - CW'(1);
                state_next   = S_EMIT_WAIT;
            end
            S_EMIT_WAIT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (count_reg == '0) begin
                        ovf_next   = 1'b0;
                        state_next = S_IDLE;
                    end else begin
                        rd_en      = 1'b1;
                        state_next = S_EMIT_LD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        px_reg    <= px_next;
        py_reg    <= py_next;
        last_reg  <= last_next;
        top_x_reg <= top_x_next;
        top_y_reg <= top_y_next;
        nx_reg    <= nx_next;
        ny_reg    <= ny_next;
        hx_reg    <= hx_next;
        hy_reg    <= hy_next;
        hend_reg  <= hend_next;
        hovf_reg  <= hovf_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_hull_x   = hx_reg;
    assign m_hull_y   = hy_reg;
    assign m_hull_end = hend_reg;
    assign m_overflow = hovf_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count above depth");

    a_valid_in_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (state_reg == S_EMIT_WAIT))
        else $error("result valid outside emission");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result is pending");

    a_done_in_cross: assert property (@(posedge aclk) disable iff (!aresetn)
        cross_st.done |-> (state_reg == S_CROSS))
        else $error("turn test finished outside its wait state");

    a_pop_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LOADN) |-> (count_reg >= CW'(2)))
        else $error("turn test started with fewer than two entries");

endmodule

### bench/tb.sv
// Self-checking testbench for the convex hull stack scan unit.
`timescale 1ns / 100ps

module tb;
    import chss_pkg::*;

    localparam int     LIMIT_CYCLES = 400000;
    localparam int     DRAIN_CYCLES = 64;
    localparam int     TARGET_ITEMS = 400;
    localparam coord_t C_MAX        = 32'sh7FFF_FFFF;
    localparam coord_t C_MIN        = 32'sh8000_0000;

    typedef struct {
        coord_t x;
        coord_t y;
        bit     pivot;
        bit     last;
    } point_item_t;

    typedef struct {
        coord_t x;
        coord_t y;
        bit     end_vtx;
        bit     ovf;
    } hull_vtx_t;

    logic   aclk       = 1'b0;
    logic   aresetn    = 1'b0;
    logic   s_valid    = 1'b0;
    logic   s_ready;
    coord_t s_point_x  = '0;
    coord_t s_point_y  = '0;
    logic   s_is_pivot = 1'b0;
    logic   s_is_last  = 1'b0;
    logic   m_valid;
    logic   m_ready    = 1'b0;
    coord_t m_hull_x;
    coord_t m_hull_y;
    logic   m_hull_end;
    logic   m_overflow;

    convex_hull_stack_scan_unit u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_point_x  (s_point_x),
        .s_point_y  (s_point_y),
        .s_is_pivot (s_is_pivot),
        .s_is_last  (s_is_last),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_hull_x   (m_hull_x),
        .m_hull_y   (m_hull_y),
        .m_hull_end (m_hull_end),
        .m_overflow (m_overflow)
    );

    point_item_t point_q[$];
    hull_vtx_t   hull_exp_q[$];
    point_item_t next_pt;
    hull_vtx_t   got_vtx;
    hull_vtx_t   want_vtx;

    // Shadow copy of the hull stack.
    coord_t shadow_x[CHSS_STACK_DEPTH];
    coord_t shadow_y[CHSS_STACK_DEPTH];
    int     shadow_depth = 0;
    bit     shadow_ovf   = 1'b0;

    int cyc        = 0;
    int err_cnt    = 0;
    int pts_taken  = 0;
    int vtx_seen   = 0;
    int hulls_seen = 0;
    int ovf_hulls  = 0;
    int ovf_runs   = 0;
    int item_total = 0;
    bit in_fire    = 1'b0;
    int in_gap     = 0;
    int out_gap    = 0;
    int in_calm    = 0;
    int out_calm   = 0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what);
        if (err_cnt < 100)
            $display("MISMATCH cycle %0d: %s", cyc, what);
        err_cnt++;
    endtask

    // Mostly short gaps, a few long ones, and now and then a stretch with none.
    function automatic int pick_gap(inout int calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if (r < 2) begin
            calm = $urandom_range(30, 80);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Strict counter-clockwise turn from the next-to-top entry through the top to the point.
    function automatic bit turns_left(input coord_t px, input coord_t py);
        logic signed [127:0] nx, ny, dtx, dty, dpx, dpy;
        nx  = shadow_x[shadow_depth-2];
        ny  = shadow_y[shadow_depth-2];
        dtx = shadow_x[shadow_depth-1];
        dty = shadow_y[shadow_depth-1];
        dpx = px;
        dpy = py;
        dtx = dtx - nx;
        dty = dty - ny;
        dpx = dpx - nx;
        dpy = dpy - ny;
        return (dtx * dpy) > (dty * dpx);
    endfunction

    task automatic predict_hull_step(input point_item_t it);
        int        k;
        hull_vtx_t v;
        if (it.pivot) begin
            shadow_depth = 0;
            shadow_ovf   = 1'b0;
        end else begin
            while (shadow_depth >= 2 && !turns_left(it.x, it.y))
                shadow_depth--;
        end
        if (shadow_depth >= CHSS_STACK_DEPTH) begin
            shadow_ovf = 1'b1;
        end else begin
            shadow_x[shadow_depth] = it.x;
            shadow_y[shadow_depth] = it.y;
            shadow_depth++;
        end
        if (it.last) begin
            for (k = shadow_depth - 1; k >= 0; k--) begin
                v.x       = shadow_x[k];
                v.y       = shadow_y[k];
                v.end_vtx = (k == 0);
                v.ovf     = shadow_ovf;
                hull_exp_q = {hull_exp_q, v};
            end
            shadow_depth = 0;
            shadow_ovf   = 1'b0;
        end
    endtask

    task automatic add_pt(input coord_t x, input coord_t y, input bit piv, input bit lst);
        point_item_t it;
        it.x     = x;
        it.y     = y;
        it.pivot = piv;
        it.last  = lst;
        point_q = {point_q, it};
        item_total++;
    endtask

    // A pivot followed by points along a parabola, optionally jittered so that some pop.
    task automatic add_curve(input int n, input int step_max, input int div, input int jit,
                             input bit close_it);
        longint x0, y0, dx, y;
        int     i;
        x0 = longint'($urandom_range(0, 2000000)) - 1000000;
        y0 = longint'($urandom_range(0, 2000000)) - 1000000;
        dx = 0;
        add_pt(coord_t'(x0), coord_t'(y0), 1'b1, 1'b0);
        for (i = 1; i < n; i++) begin
            dx += $urandom_range(1, step_max);
            y = y0 + (dx * dx) / div;
            if (jit > 0)
                y += longint'($urandom_range(0, 2 * jit)) - jit;
            add_pt(coord_t'(x0 + dx), coord_t'(y), 1'b0, close_it && (i == n - 1));
        end
    endtask

    // Full-range coordinates exercise the wide cross product.
    task automatic add_scatter(input int n);
        int i;
        bit close_it;
        close_it = ($urandom_range(0, 7) != 0);
        add_pt(coord_t'($urandom), coord_t'($urandom), 1'b1, 1'b0);
        for (i = 1; i < n; i++)
            add_pt(coord_t'($urandom), coord_t'($urandom), 1'b0, close_it && (i == n - 1));
    endtask

    task automatic add_noise(input int n);
        int i;
        for (i = 0; i < n; i++)
            add_pt(coord_t'($urandom), coord_t'($urandom), $urandom_range(0, 3) == 0,
                   $urandom_range(0, 3) == 0);
    endtask

    // Input driver: presents one pending item at a time, holding it until taken.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !in_fire) begin
            s_valid <= 1'b1;
        end else if (in_gap > 0) begin
            s_valid <= 1'b0;
            in_gap  = in_gap - 1;
        end else if (point_q.size() > 0) begin
            next_pt = point_q.pop_front();
            s_valid    <= 1'b1;
            s_point_x  <= next_pt.x;
            s_point_y  <= next_pt.y;
            s_is_pivot <= next_pt.pivot;
            s_is_last  <= next_pt.last;
            in_gap = pick_gap(in_calm);
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Result side back-pressure.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (out_gap > 0) begin
            m_ready <= 1'b0;
            out_gap = out_gap - 1;
        end else begin
            m_ready <= 1'b1;
            out_gap = pick_gap(out_calm);
        end
    end

    // Monitor: predicts on every accepted point and checks every accepted vertex.
    always @(posedge aclk) begin
        cyc++;
        if (cyc > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles", cyc);
            $display("Regression FAIL");
            $finish;
        end else begin
            in_fire = aresetn && s_valid && s_ready;
            if (in_fire) begin
                next_pt.x     = s_point_x;
                next_pt.y     = s_point_y;
                next_pt.pivot = s_is_pivot;
                next_pt.last  = s_is_last;
                predict_hull_step(next_pt);
                pts_taken++;
            end
            if (aresetn && m_valid && m_ready) begin
                got_vtx.x       = m_hull_x;
                got_vtx.y       = m_hull_y;
                got_vtx.end_vtx = m_hull_end;
                got_vtx.ovf     = m_overflow;
                vtx_seen++;
                if (hull_exp_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected vertex (%0d, %0d)",
                                              got_vtx.x, got_vtx.y));
                end else begin
                    want_vtx = hull_exp_q.pop_front();
                    if (got_vtx.x !== want_vtx.x)
                        report_mismatch($sformatf("hull_x got %0d want %0d",
                                                  got_vtx.x, want_vtx.x));
                    if (got_vtx.y !== want_vtx.y)
                        report_mismatch($sformatf("hull_y got %0d want %0d",
                                                  got_vtx.y, want_vtx.y));
                    if (got_vtx.end_vtx !== want_vtx.end_vtx)
                        report_mismatch($sformatf("hull_end got %b want %b",
                                                  got_vtx.end_vtx, want_vtx.end_vtx));
                    if (got_vtx.ovf !== want_vtx.ovf)
                        report_mismatch($sformatf("overflow got %b want %b",
                                                  got_vtx.ovf, want_vtx.ovf));
                    if (want_vtx.end_vtx) begin
                        hulls_seen++;
                        if (want_vtx.ovf)
                            ovf_hulls++;
                    end
                end
            end
        end
    end

    initial begin
        int r;

        // A point with no pivot on the empty stack after reset.
        add_pt(32'sd3, 32'sd4, 1'b0, 1'b1);
        // Pivot and last on one item give a one-vertex hull.
        add_pt(C_MIN, C_MAX, 1'b1, 1'b1);
        // Collinear points along a diagonal are dropped.
        add_pt(32'sd0, 32'sd0, 1'b1, 1'b0);
        add_pt(32'sd1, 32'sd1, 1'b0, 1'b0);
        add_pt(32'sd2, 32'sd2, 1'b0, 1'b0);
        add_pt(32'sd3, 32'sd3, 1'b0, 1'b0);
        add_pt(32'sd0, 32'sd5, 1'b0, 1'b1);
        // Corners of the coordinate range, then an interior point that still turns left and is pushed.
        add_pt(C_MIN, C_MIN, 1'b1, 1'b0);
        add_pt(C_MAX, C_MIN, 1'b0, 1'b0);
        add_pt(C_MAX, C_MAX, 1'b0, 1'b0);
        add_pt(C_MIN, C_MAX, 1'b0, 1'b0);
        add_pt(32'sd0, 32'sd0, 1'b0, 1'b1);
        // Repeated points give a zero cross product.
        add_pt(32'sd7, 32'sd7, 1'b1, 1'b0);
        add_pt(32'sd7, 32'sd7, 1'b0, 1'b0);
        add_pt(32'sd7, 32'sd7, 1'b0, 1'b1);
        // All-ones and sign-bit patterns.
        add_pt(-32'sd1, -32'sd1, 1'b1, 1'b0);
        add_pt(32'sd0, C_MIN, 1'b0, 1'b0);
        add_pt(C_MAX, 32'sd0, 1'b0, 1'b1);

        while (item_total < TARGET_ITEMS) begin
            r = $urandom_range(0, 9);
            if ((item_total >= 100 && ovf_runs == 0) || (item_total >= 250 && ovf_runs == 1)) begin
                // More strictly convex points than the stack can hold.
                add_curve($urandom_range(68, 72), 3, 1, 0, 1'b1);
                ovf_runs++;
            end else if (r < 5) begin
                add_curve($urandom_range(3, 16), 800, 64, $urandom_range(0, 3000),
                          $urandom_range(0, 9) != 0);
            end else if (r < 8) begin
                add_scatter($urandom_range(2, 10));
            end else if (r < 9) begin
                add_noise($urandom_range(1, 4));
            end else begin
                add_curve($urandom_range(20, 40), 800, 64, $urandom_range(0, 500), 1'b1);
            end
        end
        add_pt(32'sd1, 32'sd2, 1'b0, 1'b1);

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (point_q.size() > 0 || s_valid || hull_exp_q.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        while (hull_exp_q.size() > 0) begin
            want_vtx = hull_exp_q.pop_front();
            report_mismatch($sformatf("vertex (%0d, %0d) never emitted", want_vtx.x, want_vtx.y));
        end

        $display("Covered %0d points and %0d hulls with %0d vertices checked.",
                 pts_taken, hulls_seen, vtx_seen);
        $display("Hulls with a dropped push: %0d; mismatches: %0d.", ovf_hulls, err_cnt);
        if (err_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
